// ===== rtl/rtp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rtp_pkg;

    localparam int FIXED_HEADER_BYTES = 12;
    localparam int EXT_HDR_BYTES      = 4;
    localparam int POS_W              = 16;
    localparam int START_W            = 19;
    localparam int CE_W               = 7;

    localparam logic [POS_W-1:0] MAX_PACKET_BYTES = 16'hFFFF;
    localparam logic [1:0]       RTP_VERSION      = 2'd2;

    // byte index inside the four-byte extension header
    localparam logic [1:0] EXT_LEN_HI_IDX = 2'd2;
    localparam logic [1:0] EXT_LEN_LO_IDX = 2'd3;
    localparam logic [1:0] HELD_MAX       = 2'd3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        end_of_packet;
        logic        header_accepted;
        logic [15:0] recent_sequence;
        logic [31:0] recent_timestamp;
    } out_item_t;

    // one classified byte: n_held held bytes first, then the final result
    typedef struct packed {
        logic [7:0]  held0;
        logic [7:0]  held1;
        logic [1:0]  n_held;
        logic [7:0]  final_byte;
        logic        payload_valid;
        logic        end_of_packet;
        logic        header_accepted;
        logic [15:0] sequence_num;
        logic [31:0] timestamp;
    } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/rtp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rtp_front (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             accept,
    input  wire rtp_pkg::in_item_t in_data,
    output logic            cmd_push,
    output rtp_pkg::cmd_t   cmd
);
    import rtp_pkg::*;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]         fhb_reg, fhb_next;
    logic [15:0]        pend_seq_reg, pend_seq_next;
    logic [31:0]        pend_ts_reg, pend_ts_next;
    logic [15:0]        acc_seq_reg, acc_seq_next;
    logic [31:0]        acc_ts_reg, acc_ts_next;
    logic [START_W-1:0] start_reg, start_next;
    logic [7:0]         ext_hi_reg, ext_hi_next;
    logic [7:0]         held0_reg, held0_next;
    logic [7:0]         held1_reg, held1_next;
    logic [1:0]         held_cnt_reg, held_cnt_next;
    logic               ok_reg, ok_next;

    logic [7:0]      b;
    logic            last;
    logic [CE_W-1:0] ce;
    logic [CE_W-1:0] ce_end;
    logic            hdr_end;
    logic            hdr_pass;
    logic            in_body;
    logic            in_win;
    logic            flush;
    logic            payload;

    always_comb
    begin
        b        = in_data.data_byte;
        last     = in_data.last_byte;
        ce       = CE_W'(FIXED_HEADER_BYTES) + {1'b0, fhb_reg[3:0], 2'b00};
        ce_end   = ce + CE_W'(EXT_HDR_BYTES);
        hdr_end  = (pos_reg == POS_W'(FIXED_HEADER_BYTES - 1));
        hdr_pass = hdr_end && (fhb_reg[7:6] == RTP_VERSION);
        in_body  = ok_reg && (pos_reg >= POS_W'(FIXED_HEADER_BYTES));
        in_win   = in_body && fhb_reg[4]
                   && (pos_reg >= {{(POS_W-CE_W){1'b0}}, ce})
                   && (pos_reg <  {{(POS_W-CE_W){1'b0}}, ce_end});

        pos_next      = pos_reg;
        fhb_next      = fhb_reg;
        pend_seq_next = pend_seq_reg;
        pend_ts_next  = pend_ts_reg;
        acc_seq_next  = acc_seq_reg;
        acc_ts_next   = acc_ts_reg;
        start_next    = start_reg;
        ext_hi_next   = ext_hi_reg;
        held0_next    = held0_reg;
        held1_next    = held1_reg;
        held_cnt_next = held_cnt_reg;
        ok_next       = ok_reg;
        flush         = 1'b0;
        payload       = 1'b0;

        // header field capture
        if (pos_reg == POS_W'(0))
        begin
            fhb_next = b;
        end
        else if (pos_reg == POS_W'(2) || pos_reg == POS_W'(3))
        begin
            pend_seq_next = {pend_seq_reg[7:0], b};
        end
        else if (pos_reg >= POS_W'(4) && pos_reg <= POS_W'(7))
        begin
            pend_ts_next = {pend_ts_reg[23:0], b};
        end

        if (hdr_end)
        begin
            if (hdr_pass)
            begin
                ok_next      = 1'b1;
                acc_seq_next = pend_seq_reg;
                acc_ts_next  = pend_ts_reg;
                start_next   = START_W'(ce);
            end
        end
        else if (in_win)
        begin
            // ce is a multiple of four, so the low bits give the window index
            if (pos_reg[1:0] == EXT_LEN_HI_IDX)
            begin
                ext_hi_next = b;
            end
            if (pos_reg[1:0] == EXT_LEN_LO_IDX)
            begin
                start_next    = {1'b0, ext_hi_reg, b, 2'b00} + START_W'(ce)
                                + START_W'(EXT_HDR_BYTES);
                held_cnt_next = 2'd0;
            end
            else if (last)
            begin
                flush = 1'b1;
            end
            else if (held_cnt_reg < HELD_MAX)
            begin
                if (held_cnt_reg == 2'd0)
                begin
                    held0_next = b;
                end
                else if (held_cnt_reg == 2'd1)
                begin
                    held1_next = b;
                end
                held_cnt_next = held_cnt_reg + 2'd1;
            end
        end
        else if (in_body && ({{(START_W-POS_W){1'b0}}, pos_reg} >= start_reg))
        begin
            payload = 1'b1;
        end

        if (last)
        begin
            pos_next      = '0;
            start_next    = START_W'(FIXED_HEADER_BYTES);
            ext_hi_next   = 8'd0;
            held_cnt_next = 2'd0;
            ok_next       = 1'b0;
        end
        else if (pos_reg < MAX_PACKET_BYTES)
        begin
            pos_next = pos_reg + POS_W'(1);
        end

        cmd_push            = accept && (flush || payload || last);
        cmd.held0           = held0_reg;
        cmd.held1           = held1_reg;
        cmd.n_held          = flush ? held_cnt_reg : 2'd0;
        cmd.final_byte      = (flush || payload) ? b : 8'd0;
        cmd.payload_valid   = flush || payload;
        cmd.end_of_packet   = last;
        cmd.header_accepted = ok_reg || hdr_pass;
        cmd.sequence_num    = acc_seq_next;
        cmd.timestamp       = acc_ts_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            fhb_reg      <= '0;
            pend_seq_reg <= '0;
            pend_ts_reg  <= '0;
            acc_seq_reg  <= '0;
            acc_ts_reg   <= '0;
            start_reg    <= START_W'(FIXED_HEADER_BYTES);
            ext_hi_reg   <= '0;
            held_cnt_reg <= '0;
            ok_reg       <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg      <= pos_next;
            fhb_reg      <= fhb_next;
            pend_seq_reg <= pend_seq_next;
            pend_ts_reg  <= pend_ts_next;
            acc_seq_reg  <= acc_seq_next;
            acc_ts_reg   <= acc_ts_next;
            start_reg    <= start_next;
            ext_hi_reg   <= ext_hi_next;
            held_cnt_reg <= held_cnt_next;
            ok_reg       <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

    // an accepted header is only ever seen past the fixed header
    a_ok_past_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        ok_reg |-> (pos_reg >= POS_W'(FIXED_HEADER_BYTES)))
        else $error("packet accepted before fixed header complete");

    // a last byte always restarts the packet
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.last_byte) |=> (pos_reg == '0 && !ok_reg))
        else $error("per-packet state not cleared after last byte");

    // a flush never carries more held bytes than the window index
    a_flush_held: assert property (@(posedge clk) disable iff (!rst_n)
        flush |-> (held_cnt_reg == pos_reg[1:0]))
        else $error("held byte count out of step with extension window");
endmodule
`default_nettype wire

// ===== rtl/rtp_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rtp_cmd_fifo (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           push,
    input  wire rtp_pkg::cmd_t wr_cmd,
    output logic          full,
    input  wire           pop,
    output logic          head_valid,
    output rtp_pkg::cmd_t head
);
    import rtp_pkg::*;

    cmd_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign full       = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (FIFO_AW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("request queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("request queue underflow");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
endmodule
`default_nettype wire

// ===== rtl/rtp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rtp_back (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               cmd_valid,
    input  wire rtp_pkg::cmd_t cmd,
    output logic              cmd_pop,
    input  wire               pop,
    output logic              empty,
    output rtp_pkg::out_item_t out_data
);
    import rtp_pkg::*;

    out_item_t  out_reg, out_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] sub_reg, sub_next;
    logic       load;
    logic       cmd_done;

    always_comb
    begin
        load     = cmd_valid && (!out_valid_reg || pop);
        cmd_done = (sub_reg == cmd.n_held);
        cmd_pop  = load && cmd_done;

        sub_next = sub_reg;
        if (load)
        begin
            sub_next = cmd_done ? 2'd0 : sub_reg + 2'd1;
        end

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end

        out_next.header_accepted  = cmd.header_accepted;
        out_next.recent_sequence  = cmd.sequence_num;
        out_next.recent_timestamp = cmd.timestamp;
        if (cmd_done)
        begin
            out_next.payload_byte  = cmd.final_byte;
            out_next.payload_valid = cmd.payload_valid;
            out_next.end_of_packet = cmd.end_of_packet;
        end
        else
        begin
            out_next.payload_byte  = (sub_reg == 2'd0) ? cmd.held0 : cmd.held1;
            out_next.payload_valid = 1'b1;
            out_next.end_of_packet = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sub_reg       <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_data = out_reg;

    // sub-result index stays inside the request at the queue head
    a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> (sub_reg <= cmd.n_held))
        else $error("sub-result index past request");

    // index only moves while a request is present
    a_sub_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_valid |-> (sub_reg == 2'd0))
        else $error("sub-result index left over with no request");

    // a request leaves the queue only together with its final result
    a_pop_final: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (out_valid_reg && (out_reg.end_of_packet || out_reg.payload_valid)))
        else $error("request retired without a final result");
endmodule
`default_nettype wire

// ===== rtl/rtp_payload_extractor_unit.sv =====
// path: each request is written into the request queue, then into the output register
// throughput: one byte per cycle while the request queue has room; a byte that flushes
//   held extension bytes puts up to three results out, one per cycle while pop is high
// reset: rst_n asynchronous active low; clears packet position, checks and
//   recent sequence/timestamp, empties the request queue and the output register
`timescale 1ns / 1ps
`default_nettype none
module rtp_payload_extractor_unit (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    output logic               full,
    input  wire rtp_pkg::in_item_t in_data,
    input  wire                pop,
    output logic               empty,
    output rtp_pkg::out_item_t out_data
);
    import rtp_pkg::*;

    // input side handshake
    logic accept;

    // front to queue
    logic cmd_push;
    cmd_t cmd_in;

    // queue to back
    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd_head;

    // a byte is taken whenever the request queue has room
    assign accept = push && !full;

    // front: tracks the byte position, checks the version, walks the csrc list and
    // extension header, and turns payload, flushing and last bytes into requests
    rtp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_data  (in_data),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    // short queue decouples header parsing from result delivery
    rtp_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .wr_cmd     (cmd_in),
        .full       (full),
        .pop        (cmd_pop),
        .head_valid (cmd_valid),
        .head       (cmd_head)
    );

    // back: expands each request into one to three results through the
    // output register
    rtp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .out_data  (out_data)
    );

    // every request carries at least one result, so the output does not stay
    // empty while a request waits
    a_out_fed: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && empty) |=> !empty)
        else $error("output stayed empty with a request waiting");

    // a full queue implies the back side has something to deliver
    a_full_means_busy: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> cmd_valid)
        else $error("queue full but no request at head");

    // results never appear without a request having been taken from the queue
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        ($fell(empty)) |-> $past(cmd_valid))
        else $error("result produced without a request");
endmodule
`default_nettype wire
